// File: rtl/core/lplt_pkg.sv
// ----------------------------------------------------------------------------
// lplt_pkg
// Shared types and constants for the laser pulse lockout timer.
// ----------------------------------------------------------------------------
package lplt_pkg;

   localparam int MODE_W  = 3;
   localparam int COUNT_W = 8;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 8;
   localparam int TIME_W  = 32;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ON    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIRE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIRE_ON    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOCKOUT    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLIP_ON    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLIP_PERIOD = 8'd3;

   // Register reset values, milliseconds
   localparam logic [CFG_W-1:0] FIRE_ON_RESET     = 16'd250;
   localparam logic [CFG_W-1:0] LOCKOUT_RESET     = 16'd750;
   localparam logic [CFG_W-1:0] BLIP_ON_RESET     = 16'd100;
   localparam logic [CFG_W-1:0] BLIP_PERIOD_RESET = 16'd500;

   typedef struct packed {
      logic [CFG_W-1:0] fire_on_ms;
      logic [CFG_W-1:0] lockout_ms;
      logic [CFG_W-1:0] blip_on_ms;
      logic [CFG_W-1:0] blip_period_ms;
   } cfg_type;

   typedef struct packed {
      logic laser_level;
      logic burst_done;
   } res_type;

   // Wrap-safe "t is past d": signed difference strictly positive
   function automatic logic is_past(input logic [TIME_W-1:0] t,
                                    input logic [TIME_W-1:0] d);
      logic [TIME_W-1:0] diff;
      diff = t - d;
      return (diff != '0) && !diff[TIME_W-1];
   endfunction

endpackage

// File: rtl/core/lplt_if.sv
// ----------------------------------------------------------------------------
// lplt channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface lplt_req_if;
   logic                        valid;
   logic                        ready;
   logic [lplt_pkg::MODE_W-1:0]  mode;
   logic [lplt_pkg::COUNT_W-1:0] burst_count;

   modport source (output valid, output mode, output burst_count, input ready);
   modport sink   (input valid, input mode, input burst_count, output ready);
endinterface

interface lplt_rsp_if;
   logic valid;
   logic ready;
   logic laser_level;
   logic burst_done;

   modport source (output valid, output laser_level, output burst_done, input ready);
   modport sink   (input valid, input laser_level, input burst_done, output ready);
endinterface

interface lplt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lplt_pkg::CSR_IDX_W-1:0] index;
   logic [lplt_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/lplt_core.sv
// ----------------------------------------------------------------------------
// lplt_core
// Timer state: tick count, off/blip/lockout deadlines, burst counter, laser.
// ----------------------------------------------------------------------------
module lplt_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  logic [lplt_pkg::MODE_W-1:0]  mode,
   input  logic [lplt_pkg::COUNT_W-1:0] burst_count,
   input  lplt_pkg::cfg_type            cfg,
   output lplt_pkg::res_type            res
);
   import lplt_pkg::*;

   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  off_dl_ff, off_dl_in;
   logic               off_armed_ff, off_armed_in;
   logic [TIME_W-1:0]  blip_dl_ff, blip_dl_in;
   logic [TIME_W-1:0]  allow_dl_ff, allow_dl_in;
   logic               allow_armed_ff, allow_armed_in;
   logic               blip_en_ff, blip_en_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic               laser_ff, laser_in;
   logic               done;

   logic [TIME_W-1:0]          tick_now;
   logic [CFG_W+COUNT_W-1:0]   lock_prod;

   assign tick_now  = now_ff + TIME_W'(1);
   assign lock_prod = cfg.lockout_ms * burst_count;

   always_comb begin
      now_in         = now_ff;
      off_dl_in      = off_dl_ff;
      off_armed_in   = off_armed_ff;
      blip_dl_in     = blip_dl_ff;
      allow_dl_in    = allow_dl_ff;
      allow_armed_in = allow_armed_ff;
      blip_en_in     = blip_en_ff;
      left_in        = left_ff;
      laser_in       = laser_ff;
      done           = 1'b0;

      unique case (mode)
         MODE_TICK: begin
            now_in = tick_now;
            if (allow_armed_ff && is_past(tick_now, allow_dl_ff))
               allow_armed_in = 1'b0;
            if (off_armed_ff && is_past(tick_now, off_dl_ff)) begin
               laser_in     = 1'b0;
               off_armed_in = 1'b0;
            end
            if (is_past(tick_now, blip_dl_ff)) begin
               if (blip_en_ff)
                  laser_in = 1'b1;
               off_dl_in    = tick_now + TIME_W'(cfg.blip_on_ms);
               off_armed_in = 1'b1;
               blip_dl_in   = tick_now + TIME_W'(cfg.blip_period_ms);
               if (left_ff != '0) begin
                  left_in = left_ff - COUNT_W'(1);
                  // last blip of a counted burst
                  if (left_ff == COUNT_W'(1)) begin
                     blip_en_in = 1'b0;
                     done       = 1'b1;
                  end
               end
            end
         end
         MODE_OFF: begin
            blip_en_in = 1'b0;
         end
         MODE_ON: begin
            blip_en_in   = 1'b1;
            laser_in     = 1'b1;
            off_dl_in    = now_ff + TIME_W'(cfg.blip_on_ms);
            off_armed_in = 1'b1;
            blip_dl_in   = now_ff + TIME_W'(cfg.blip_period_ms);
         end
         MODE_FIRE: begin
            if (!allow_armed_ff) begin
               laser_in       = 1'b1;
               off_dl_in      = now_ff + TIME_W'(cfg.fire_on_ms);
               off_armed_in   = 1'b1;
               allow_dl_in    = now_ff + TIME_W'(cfg.lockout_ms);
               allow_armed_in = 1'b1;
            end
         end
         MODE_COUNT: begin
            if (!allow_armed_ff) begin
               laser_in       = 1'b1;
               blip_en_in     = 1'b1;
               off_dl_in      = now_ff + TIME_W'(cfg.blip_on_ms);
               off_armed_in   = 1'b1;
               blip_dl_in     = now_ff + TIME_W'(cfg.blip_period_ms);
               allow_dl_in    = now_ff + TIME_W'(lock_prod);
               allow_armed_in = 1'b1;
            end
            left_in = (burst_count == '0) ? '0 : burst_count - COUNT_W'(1);
         end
         default: begin
            // unused modes leave state alone
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         off_dl_ff      <= '0;
         off_armed_ff   <= 1'b0;
         blip_dl_ff     <= '0;
         allow_dl_ff    <= '0;
         allow_armed_ff <= 1'b0;
         blip_en_ff     <= 1'b0;
         left_ff        <= '0;
         laser_ff       <= 1'b0;
      end else if (step_en) begin
         now_ff         <= now_in;
         off_dl_ff      <= off_dl_in;
         off_armed_ff   <= off_armed_in;
         blip_dl_ff     <= blip_dl_in;
         allow_dl_ff    <= allow_dl_in;
         allow_armed_ff <= allow_armed_in;
         blip_en_ff     <= blip_en_in;
         left_ff        <= left_in;
         laser_ff       <= laser_in;
      end
   end

   assign res.laser_level = laser_in;
   assign res.burst_done  = done;

endmodule

// File: rtl/core/laser_pulse_lockout_timer_unit.sv
// A result is valid the cycle after its item transfers. Throughput: one item
// per cycle while no result is stalled; the state update is a single pass of
// compares and adds on the registered deadlines, plus one 16x8 multiply.
// A new item can transfer in the same cycle as the waiting result transfers.
// Reset (synchronous) clears time, deadlines and laser and loads the
// default on, lockout, blip and period times.
// ----------------------------------------------------------------------------
// laser_pulse_lockout_timer_unit
// Millisecond laser drive timer with fire lockout and periodic/counted blips.
// ----------------------------------------------------------------------------
module laser_pulse_lockout_timer_unit (
   input logic   clock,
   input logic   reset,
   lplt_req_if.sink   req_ch,
   lplt_rsp_if.source rsp_ch,
   lplt_csr_if.sink   csr_ch
);
   import lplt_pkg::*;

   cfg_type cfg_ff;
   logic    rsp_valid_ff;
   res_type res_ff;
   res_type res_next;
   logic    req_xfer;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fire_on_ms     <= FIRE_ON_RESET;
         cfg_ff.lockout_ms     <= LOCKOUT_RESET;
         cfg_ff.blip_on_ms     <= BLIP_ON_RESET;
         cfg_ff.blip_period_ms <= BLIP_PERIOD_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FIRE_ON:     cfg_ff.fire_on_ms     <= csr_ch.data;
            REG_LOCKOUT:     cfg_ff.lockout_ms     <= csr_ch.data;
            REG_BLIP_ON:     cfg_ff.blip_on_ms     <= csr_ch.data;
            REG_BLIP_PERIOD: cfg_ff.blip_period_ms <= csr_ch.data;
            default: ; // index beyond the register list
         endcase
      end
   end

   lplt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_xfer),
      .mode        (req_ch.mode),
      .burst_count (req_ch.burst_count),
      .cfg         (cfg_ff),
      .res         (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer)
         res_ff <= res_next;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.laser_level = res_ff.laser_level;
   assign rsp_ch.burst_done  = res_ff.burst_done;

endmodule

// File: tb/sv/tb_laser_pulse_lockout_timer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laser_pulse_lockout_timer_unit
// Self-checking bench for the laser lockout timer. Ticks and commands are
// streamed in with random gaps and output stalls. A predictor tracks time,
// deadlines and the laser level, and each result is compared in order.
// Register settings range from tiny values to the 16-bit limits.
// ----------------------------------------------------------------------------
module tb_laser_pulse_lockout_timer_unit;
   import lplt_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 220;

   // Predicts the laser level and burst completion for every item transfer
   class laser_level_tracker;
      logic [CFG_W-1:0]  fire_on;
      logic [CFG_W-1:0]  lockout;
      logic [CFG_W-1:0]  blip_on;
      logic [CFG_W-1:0]  blip_period;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] off_at;
      logic [TIME_W-1:0] blip_at;
      logic [TIME_W-1:0] allow_at;
      logic              off_pending;
      logic              fire_locked;
      logic              blips_on;
      logic [COUNT_W-1:0] blips_left;
      logic              laser;
      res_type           pending_levels[$];
      int                errors;

      function new();
         fire_on     = FIRE_ON_RESET;
         lockout     = LOCKOUT_RESET;
         blip_on     = BLIP_ON_RESET;
         blip_period = BLIP_PERIOD_RESET;
         now_ms      = '0;
         off_at      = '0;
         blip_at     = '0;
         allow_at    = '0;
         off_pending = 1'b0;
         fire_locked = 1'b0;
         blips_on    = 1'b0;
         blips_left  = '0;
         laser       = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_FIRE_ON:     fire_on = value;
            REG_LOCKOUT:     lockout = value;
            REG_BLIP_ON:     blip_on = value;
            REG_BLIP_PERIOD: blip_period = value;
            default: ;
         endcase
      endfunction

      // signed 32-bit difference strictly positive
      function logic passed(logic [TIME_W-1:0] t, logic [TIME_W-1:0] d);
         logic [TIME_W-1:0] diff;
         diff = t - d;
         return (diff != '0) && !diff[TIME_W-1];
      endfunction

      function void restart_blip();
         off_at      = now_ms + TIME_W'(blip_on);
         off_pending = 1'b1;
         blip_at     = now_ms + TIME_W'(blip_period);
      endfunction

      function void apply_item(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
         logic done;
         done = 1'b0;
         case (mode)
            MODE_TICK: begin
               now_ms = now_ms + TIME_W'(1);
               if (fire_locked && passed(now_ms, allow_at))
                  fire_locked = 1'b0;
               if (off_pending && passed(now_ms, off_at)) begin
                  laser       = 1'b0;
                  off_pending = 1'b0;
               end
               if (passed(now_ms, blip_at)) begin
                  if (blips_on)
                     laser = 1'b1;
                  restart_blip();
                  if (blips_left != '0) begin
                     blips_left = blips_left - COUNT_W'(1);
                     if (blips_left == '0) begin
                        blips_on = 1'b0;
                        done     = 1'b1;
                     end
                  end
               end
            end
            MODE_OFF: blips_on = 1'b0;
            MODE_ON: begin
               blips_on = 1'b1;
               laser    = 1'b1;
               restart_blip();
            end
            MODE_FIRE: begin
               if (!fire_locked) begin
                  laser       = 1'b1;
                  off_at      = now_ms + TIME_W'(fire_on);
                  off_pending = 1'b1;
                  allow_at    = now_ms + TIME_W'(lockout);
                  fire_locked = 1'b1;
               end
            end
            MODE_COUNT: begin
               if (!fire_locked) begin
                  laser    = 1'b1;
                  blips_on = 1'b1;
                  restart_blip();
                  allow_at    = now_ms + TIME_W'(lockout) * TIME_W'(count);
                  fire_locked = 1'b1;
               end
               // count is loaded even when the fire is refused
               blips_left = (count == '0) ? '0 : count - COUNT_W'(1);
            end
            default: ;
         endcase
         pending_levels.push_back('{laser_level: laser, burst_done: done});
      endfunction

      function void check_output(logic level, logic done);
         res_type exp_res;
         if (pending_levels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: laser_level %0b burst_done %0b", level, done);
            return;
         end
         exp_res = pending_levels.pop_front();
         if (level !== exp_res.laser_level) begin
            errors++;
            if (errors <= 10)
               $display("mismatch laser_level: expected %0b got %0b at now_ms %0d",
                        exp_res.laser_level, level, now_ms);
         end
         if (done !== exp_res.burst_done) begin
            errors++;
            if (errors <= 10)
               $display("mismatch burst_done: expected %0b got %0b at now_ms %0d",
                        exp_res.burst_done, done, now_ms);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lplt_req_if req_ch();
   lplt_rsp_if rsp_ch();
   lplt_csr_if csr_ch();

   laser_pulse_lockout_timer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   laser_level_tracker tracker;
   logic quiet;
   int   rsp_stall;
   int   items_sent;
   int   idle_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      if ($urandom_range(0, 99) < 85) return COUNT_W'($urandom_range(0, 6));
      return COUNT_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [MODE_W-1:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return MODE_OFF;
      if (r < 35) return MODE_ON;
      if (r < 65) return MODE_FIRE;
      return MODE_COUNT;
   endfunction

   // valid stays high across back-to-back transfers
   task automatic send_item(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.burst_count <= count;
      do @(posedge clock); while (!req_ch.ready);
      tracker.apply_item(mode, count);
      items_sent++;
   endtask

   task automatic wait_drained();
      while (tracker.pending_levels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      tracker.write_reg(idx, value);
   endtask

   task automatic load_config(logic [CFG_W-1:0] fire_on, logic [CFG_W-1:0] lockout,
                              logic [CFG_W-1:0] blip_on, logic [CFG_W-1:0] period);
      req_ch.valid <= 1'b0;
      wait_drained();
      write_reg(REG_FIRE_ON, fire_on);
      write_reg(REG_LOCKOUT, lockout);
      // out-of-range index must leave the registers alone
      write_reg(CSR_IDX_W'($urandom_range(4, 255)), CFG_W'($urandom));
      write_reg(REG_BLIP_ON, blip_on);
      write_reg(REG_BLIP_PERIOD, period);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_random(int n);
      int start;
      int r;
      int run;
      start = items_sent;
      while (items_sent - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            // command followed by a run of ticks
            send_item(pick_command(), pick_count());
            run = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 30)
                                              : $urandom_range(31, 120);
            repeat (run) send_item(MODE_TICK, COUNT_W'($urandom));
         end else if (r < 90) begin
            send_item(MODE_W'($urandom_range(0, 7)), COUNT_W'($urandom));
         end else begin
            // fire attempts inside the lockout window
            repeat ($urandom_range(2, 5)) begin
               send_item(($urandom_range(0, 1) != 0) ? MODE_FIRE : MODE_COUNT, pick_count());
               repeat ($urandom_range(0, 3)) send_item(MODE_TICK, COUNT_W'($urandom));
            end
         end
      end
   endtask

   task automatic run_directed();
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_COUNT, 8'd3);
      send_item(MODE_FIRE, 8'h00);
      send_item(MODE_TICK, 8'hff);
      send_item(MODE_OFF, 8'h00);
      send_item(MODE_ON, 8'h00);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_COUNT, 8'd0);
      send_item(MODE_COUNT, 8'd1);
      send_item(MODE_COUNT, 8'd255);
      send_item(MODE_FIRE, 8'hff);
      send_item(3'd5, 8'hff);
      send_item(3'd6, 8'h00);
      send_item(3'd7, 8'haa);
      send_item(MODE_TICK, 8'h55);
      send_item(MODE_TICK, 8'h00);
      send_item(MODE_OFF, 8'hff);
      send_item(MODE_TICK, 8'h00);
   endtask

   // result side: check transfers, stall at random
   initial begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_output(rsp_ch.laser_level, rsp_ch.burst_done);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               rsp_stall = pick_gap();
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      tracker = new();
      quiet = 1'b0;
      items_sent = 0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_TICK;
      req_ch.burst_count <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(PHASE_ITEMS - 20);

      quiet = 1'b1;
      load_config(16'd3, 16'd5, 16'd2, 16'd6);
      run_random(PHASE_ITEMS);

      // all zero, blip logic runs on every tick
      quiet = 1'b0;
      load_config(16'd0, 16'd0, 16'd0, 16'd0);
      send_item(MODE_ON, 8'h00);
      repeat (3) send_item(MODE_TICK, 8'h00);
      send_item(MODE_COUNT, 8'd2);
      repeat (3) send_item(MODE_TICK, 8'h00);
      run_random(PHASE_ITEMS);

      load_config(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      run_random(PHASE_ITEMS);

      load_config(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 25)),
                  CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(1, 15)));
      run_random(PHASE_ITEMS);

      quiet = 1'b1;
      load_config(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 25)),
                  CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(1, 15)));
      run_random(PHASE_ITEMS);

      // blip on time longer than the period
      quiet = 1'b0;
      load_config(16'd1, 16'hffff, 16'hffff, 16'd1);
      run_random(PHASE_ITEMS);

      load_config(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 25)),
                  CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(1, 15)));
      run_random(PHASE_ITEMS);

      req_ch.valid <= 1'b0;
      while (tracker.pending_levels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_levels.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: laser_pulse_lockout_timer_unit.f
rtl/core/lplt_pkg.sv
rtl/core/lplt_if.sv
rtl/core/lplt_core.sv
rtl/core/laser_pulse_lockout_timer_unit.sv
tb/sv/tb_laser_pulse_lockout_timer_unit.sv
